### rtl/scalar_kalman_filter_core_defines.svh
// Assertion helpers for the scalar Kalman filter core.
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge, muted in reset.
`define SKF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skf: same-cycle check failed");

// Next-cycle implication, checked on the rising edge, muted in reset.
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skf: next-cycle check failed");

`endif

### rtl/skf_pkg.sv
package skf_pkg;

  // register file
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_STATE_GAIN    = 3'd0,
    REG_MEAS_GAIN     = 3'd1,
    REG_PROCESS_NOISE = 3'd2,
    REG_MEAS_NOISE    = 3'd3,
    REG_INIT_ESTIMATE = 3'd4,
    REG_INIT_VARIANCE = 3'd5
  } reg_idx_e;

  localparam logic [15:0] RST_STATE_GAIN    = 16'd4096;
  localparam logic [15:0] RST_MEAS_GAIN     = 16'd4096;
  localparam logic [31:0] RST_PROCESS_NOISE = 32'd6554;
  localparam logic [31:0] RST_MEAS_NOISE    = 32'd6554;
  localparam logic [31:0] RST_INIT_ESTIMATE = 32'd0;
  localparam logic [31:0] RST_INIT_VARIANCE = 32'd65536;

  // arithmetic
  localparam int unsigned GAIN_FRAC = 12;
  localparam int unsigned SQ_SHIFT  = 2 * GAIN_FRAC;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MPL_W     = 32;
  localparam int unsigned MCAND_W   = 47;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned NUM_W     = 35;
  localparam int unsigned DEN_W     = 39;
  localparam int unsigned CNT_W     = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_POST,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_AX,   // A * x            -> predicted estimate
    OP_PA,   // p * |A|
    OP_PAA,  // p * |A| * |A|    -> predicted variance
    OP_PH,   // p1 * |H|         -> numerator
    OP_PHH,  // p1 * |H| * |H|   -> denominator
    OP_HX,   // H * x1           -> innovation
    OP_DIV,  // numerator / denominator -> gain
    OP_KE,   // k * e            -> corrected estimate
    OP_KH,   // k * H            -> variance factor
    OP_FP    // f * p1           -> corrected variance
  } op_e;

endpackage

### rtl/scalar_kalman_filter_core.sv
// Filter transaction (mode 0): predict, gain division and correction run in turn;
// the gain division is skipped for a zero or overflowing denominator. The next
// input is accepted only once the result has entered the output stage.
// Reload transaction (mode 1): ST_IDLE, ST_DONE, then the output stage, one at a time.
// The filter step uses the shared 4-bit-digit multiplier and the radix-2 divider.
// rst_ni (async, active low) restores config registers, estimate 0, variance 1.0,
// and leaves the core idle with no result pending.
`include "scalar_kalman_filter_core_defines.svh"

module scalar_kalman_filter_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic signed [31:0]         measurement_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         estimate_o,
  output logic [31:0]                variance_o,
  output logic signed [31:0]         kalman_gain_o
);

  // Local copies of package widths, so they can be used in size casts.
  localparam int unsigned DIGIT_W = skf_pkg::DIGIT_W;
  localparam int unsigned MPL_W   = skf_pkg::MPL_W;
  localparam int unsigned MCAND_W = skf_pkg::MCAND_W;
  localparam int unsigned ACC_W   = skf_pkg::ACC_W;
  localparam int unsigned NUM_W   = skf_pkg::NUM_W;
  localparam int unsigned DEN_W   = skf_pkg::DEN_W;
  localparam int unsigned CNT_W   = skf_pkg::CNT_W;
  localparam int unsigned GF      = skf_pkg::GAIN_FRAC;
  localparam int unsigned SQ_SH   = skf_pkg::SQ_SHIFT;

  // Partial product of one multiplier digit, dividend width, step counts.
  localparam int unsigned PP_W       = MCAND_W + DIGIT_W;
  localparam int unsigned N_W        = NUM_W + FRAC_BITS;
  localparam int unsigned STEPS_HALF = (MPL_W / 2) / DIGIT_W;
  localparam int unsigned STEPS_FULL = MPL_W / DIGIT_W;
  localparam int unsigned DIV_STEPS  = 32;
  localparam logic signed [64:0] FB_ONE = 65'sd1 <<< FRAC_BITS;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Saturate a 65-bit two's complement value to signed 32 bits.
  function automatic logic [31:0] sat_s32(input logic [64:0] v);
    if (v[64:31] == {34{v[64]}}) begin
      sat_s32 = v[31:0];
    end else begin
      sat_s32 = v[64] ? S32_MIN : S32_MAX;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers (APB, zero wait states)
  // --------------------------------------------------------------------------
  logic signed [15:0] cfg_a_q;   // A, Q4.12
  logic signed [15:0] cfg_h_q;   // H, Q4.12
  logic [31:0]        cfg_pn_q;  // q
  logic [31:0]        cfg_mn_q;  // r
  logic signed [31:0] cfg_ie_q;  // init estimate
  logic [31:0]        cfg_iv_q;  // init variance

  skf_pkg::reg_idx_e reg_idx;
  logic              cfg_wr;

  assign reg_idx = skf_pkg::reg_idx_e'(paddr[skf_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Indexes past the register list are ignored on write and read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q  <= skf_pkg::RST_STATE_GAIN;
      cfg_h_q  <= skf_pkg::RST_MEAS_GAIN;
      cfg_pn_q <= skf_pkg::RST_PROCESS_NOISE;
      cfg_mn_q <= skf_pkg::RST_MEAS_NOISE;
      cfg_ie_q <= skf_pkg::RST_INIT_ESTIMATE;
      cfg_iv_q <= skf_pkg::RST_INIT_VARIANCE;
    end else if (cfg_wr) begin
      case (reg_idx)
        skf_pkg::REG_STATE_GAIN:    cfg_a_q  <= pwdata[15:0];
        skf_pkg::REG_MEAS_GAIN:     cfg_h_q  <= pwdata[15:0];
        skf_pkg::REG_PROCESS_NOISE: cfg_pn_q <= pwdata;
        skf_pkg::REG_MEAS_NOISE:    cfg_mn_q <= pwdata;
        skf_pkg::REG_INIT_ESTIMATE: cfg_ie_q <= pwdata;
        skf_pkg::REG_INIT_VARIANCE: cfg_iv_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      skf_pkg::REG_STATE_GAIN:    prdata = {{16{cfg_a_q[15]}}, cfg_a_q};
      skf_pkg::REG_MEAS_GAIN:     prdata = {{16{cfg_h_q[15]}}, cfg_h_q};
      skf_pkg::REG_PROCESS_NOISE: prdata = cfg_pn_q;
      skf_pkg::REG_MEAS_NOISE:    prdata = cfg_mn_q;
      skf_pkg::REG_INIT_ESTIMATE: prdata = cfg_ie_q;
      skf_pkg::REG_INIT_VARIANCE: prdata = cfg_iv_q;
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  // Control state (reset)
  skf_pkg::state_e state_q, state_d;
  skf_pkg::op_e    op_q, op_d;
  logic            out_valid_q, out_valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  // Filter state: x_q also holds x1 mid-step, p_q holds p1 mid-step.
  logic signed [31:0] x_q, x_d;
  logic [31:0]        p_q, p_d;

  // Working payload (no reset)
  logic signed [31:0] z_q, z_d;         // measurement
  logic signed [31:0] k_q, k_d;         // gain
  logic signed [31:0] e_q, e_d;         // innovation
  logic [31:0]        f_q, f_d;         // variance factor 1 - k*H
  logic [NUM_W-1:0]   num_q, num_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [MCAND_W-1:0] mcand_q, mcand_d;
  logic [MPL_W-1:0]   mplier_q, mplier_d;
  logic               neg_q, neg_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [31:0]        dq_q, dq_d;       // dividend low bits in, quotient bits out
  logic signed [31:0] est_out_q, est_out_d;
  logic [31:0]        var_out_q, var_out_d;
  logic signed [31:0] gain_out_q, gain_out_d;

  // --------------------------------------------------------------------------
  // Arithmetic around the shared units
  // --------------------------------------------------------------------------
  // Multiplier: MSB-first, one 4-bit digit of the multiplier per cycle,
  // acc = acc*16 + mcand*digit. Operands are magnitudes; neg_q gives the sign.
  logic [DIGIT_W-1:0] digit;
  logic [PP_W-1:0]    pp;
  assign digit = mplier_q[MPL_W-1 -: DIGIT_W];
  assign pp    = PP_W'(mcand_q) * PP_W'(digit);

  // Signed product and its floor shifts
  logic signed [64:0] prod_s, sh_gf, sh_fb;
  assign prod_s = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign sh_gf  = prod_s >>> GF;
  assign sh_fb  = prod_s >>> FRAC_BITS;

  logic signed [64:0] z_ext, x_ext, hx_diff, ke_sum, f_s;
  assign z_ext   = {{33{z_q[31]}}, z_q};
  assign x_ext   = {{33{x_q[31]}}, x_q};
  assign hx_diff = z_ext - sh_gf;
  assign ke_sum  = x_ext + sh_fb;
  assign f_s     = FB_ONE - sh_gf;

  // Predicted variance: (A*A*p >> 24) + q
  logic [40:0] paa_sum;
  assign paa_sum = {1'b0, acc_q[ACC_W-1:SQ_SH]} + {9'd0, cfg_pn_q};

  // Corrected variance: f*p1 >> FRAC_BITS
  logic [ACC_W-1:0] fp_sh;
  assign fp_sh = acc_q >> FRAC_BITS;

  // Divider set-up: dividend = num << FRAC_BITS. The high part starts as the
  // partial remainder; if it already reaches the divisor the quotient is at
  // least 2^32 and the gain saturates without iterating.
  logic [N_W-1:0] div_n;
  logic [DEN_W-1:0] div_hi;
  logic           div_ovf;
  assign div_n   = N_W'(num_q) << FRAC_BITS;
  assign div_hi  = DEN_W'(div_n[N_W-1:32]);
  assign div_ovf = div_hi >= den_q;

  // Radix-2 restoring step
  logic [DEN_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q, dq_q[31]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  logic in_acc;
  logic out_load;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // Next state and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_d       = cnt_q;
    x_d         = x_q;
    p_d         = p_q;
    z_d         = z_q;
    k_d         = k_q;
    e_d         = e_q;
    f_d         = f_q;
    num_d       = num_q;
    den_d       = den_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    est_out_d   = est_out_q;
    var_out_d   = var_out_q;
    gain_out_d  = gain_out_q;

    case (state_q)
      skf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            // reload: state straight from the init registers
            x_d     = cfg_ie_q;
            p_d     = cfg_iv_q;
            k_d     = '0;
            state_d = skf_pkg::ST_DONE;
          end else begin
            z_d     = measurement_i;
            op_d    = skf_pkg::OP_AX;
            state_d = skf_pkg::ST_LOAD;
          end
        end
      end

      skf_pkg::ST_LOAD: begin
        // operands for the next operation; default is a 16-bit multiplier
        acc_d   = '0;
        neg_d   = 1'b0;
        cnt_d   = CNT_W'(STEPS_HALF - 1);
        state_d = skf_pkg::ST_MUL;
        case (op_q)
          skf_pkg::OP_AX: begin
            mplier_d = {abs16(cfg_a_q), 16'd0};
            mcand_d  = MCAND_W'(abs32(x_q));
            neg_d    = cfg_a_q[15] ^ x_q[31];
          end
          skf_pkg::OP_PA: begin
            mplier_d = {abs16(cfg_a_q), 16'd0};
            mcand_d  = MCAND_W'(p_q);
          end
          skf_pkg::OP_PAA: begin
            mplier_d = {abs16(cfg_a_q), 16'd0};   // mcand holds p*|A|
          end
          skf_pkg::OP_PH: begin
            mplier_d = {abs16(cfg_h_q), 16'd0};
            mcand_d  = MCAND_W'(p_q);
          end
          skf_pkg::OP_PHH: begin
            mplier_d = {abs16(cfg_h_q), 16'd0};   // mcand holds p1*|H|
          end
          skf_pkg::OP_HX: begin
            mplier_d = {abs16(cfg_h_q), 16'd0};
            mcand_d  = MCAND_W'(abs32(x_q));
            neg_d    = cfg_h_q[15] ^ x_q[31];
          end
          skf_pkg::OP_DIV: begin
            if (den_q == '0) begin
              // zero denominator: no gain, correction leaves x1 and p1
              k_d     = '0;
              op_d    = skf_pkg::OP_KE;
              state_d = skf_pkg::ST_LOAD;
            end else if (div_ovf) begin
              k_d     = cfg_h_q[15] ? S32_MIN : S32_MAX;
              op_d    = skf_pkg::OP_KE;
              state_d = skf_pkg::ST_LOAD;
            end else begin
              rem_d   = div_hi;
              dq_d    = div_n[31:0];
              cnt_d   = CNT_W'(DIV_STEPS - 1);
              state_d = skf_pkg::ST_DIV;
            end
          end
          skf_pkg::OP_KE: begin
            mplier_d = abs32(e_q);
            mcand_d  = MCAND_W'(abs32(k_q));
            neg_d    = k_q[31] ^ e_q[31];
            cnt_d    = CNT_W'(STEPS_FULL - 1);
          end
          skf_pkg::OP_KH: begin
            mplier_d = {abs16(cfg_h_q), 16'd0};
            mcand_d  = MCAND_W'(abs32(k_q));
            neg_d    = k_q[31] ^ cfg_h_q[15];
          end
          skf_pkg::OP_FP: begin
            mplier_d = f_q;
            mcand_d  = MCAND_W'(p_q);
            cnt_d    = CNT_W'(STEPS_FULL - 1);
          end
          default: state_d = skf_pkg::ST_IDLE;
        endcase
      end

      skf_pkg::ST_MUL: begin
        acc_d    = (acc_q << DIGIT_W) + ACC_W'(pp);
        mplier_d = mplier_q << DIGIT_W;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = skf_pkg::ST_POST;
        end
      end

      skf_pkg::ST_DIV: begin
        rem_d = rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
        dq_d  = {dq_q[30:0], rem_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = skf_pkg::ST_POST;
        end
      end

      skf_pkg::ST_POST: begin
        state_d = skf_pkg::ST_LOAD;
        case (op_q)
          skf_pkg::OP_AX: begin
            x_d  = sat_s32(sh_gf);
            op_d = skf_pkg::OP_PA;
          end
          skf_pkg::OP_PA: begin
            mcand_d = acc_q[MCAND_W-1:0];
            op_d    = skf_pkg::OP_PAA;
          end
          skf_pkg::OP_PAA: begin
            p_d  = (paa_sum[40:32] != '0) ? U32_MAX : paa_sum[31:0];
            op_d = skf_pkg::OP_PH;
          end
          skf_pkg::OP_PH: begin
            num_d   = acc_q[GF +: NUM_W];
            mcand_d = acc_q[MCAND_W-1:0];
            op_d    = skf_pkg::OP_PHH;
          end
          skf_pkg::OP_PHH: begin
            den_d = DEN_W'(acc_q[ACC_W-1:SQ_SH]) + DEN_W'(cfg_mn_q);
            op_d  = skf_pkg::OP_HX;
          end
          skf_pkg::OP_HX: begin
            e_d  = sat_s32(hx_diff);
            op_d = skf_pkg::OP_DIV;
          end
          skf_pkg::OP_DIV: begin
            // quotient above 2^31 - 1 saturates; negative H flips the sign
            if (cfg_h_q[15]) begin
              k_d = dq_q[31] ? S32_MIN : (~dq_q + 32'd1);
            end else begin
              k_d = dq_q[31] ? S32_MAX : dq_q;
            end
            op_d = skf_pkg::OP_KE;
          end
          skf_pkg::OP_KE: begin
            x_d  = sat_s32(ke_sum);
            op_d = skf_pkg::OP_KH;
          end
          skf_pkg::OP_KH: begin
            // factor below zero clamps to zero, above 32 bits to all ones
            if (f_s[64]) begin
              f_d = '0;
            end else if (f_s[63:32] != '0) begin
              f_d = U32_MAX;
            end else begin
              f_d = f_s[31:0];
            end
            op_d = skf_pkg::OP_FP;
          end
          skf_pkg::OP_FP: begin
            p_d     = (fp_sh[ACC_W-1:32] != '0) ? U32_MAX : fp_sh[31:0];
            state_d = skf_pkg::ST_DONE;
          end
          default: state_d = skf_pkg::ST_IDLE;
        endcase
      end

      skf_pkg::ST_DONE: begin
        // wait here while a previous result is still held in the output stage
        if (out_load) begin
          est_out_d   = x_q;
          var_out_d   = p_q;
          gain_out_d  = k_q;
          out_valid_d = 1'b1;
          state_d     = skf_pkg::ST_IDLE;
        end
      end

      default: state_d = skf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skf_pkg::ST_IDLE;
      op_q        <= skf_pkg::OP_AX;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      x_q         <= skf_pkg::RST_INIT_ESTIMATE;
      p_q         <= skf_pkg::RST_INIT_VARIANCE;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      x_q         <= x_d;
      p_q         <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q        <= z_d;
    k_q        <= k_d;
    e_q        <= e_d;
    f_q        <= f_d;
    num_q      <= num_d;
    den_q      <= den_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    neg_q      <= neg_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    dq_q       <= dq_d;
    est_out_q  <= est_out_d;
    var_out_q  <= var_out_d;
    gain_out_q <= gain_out_d;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_ready_o    = (state_q == skf_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign estimate_o    = est_out_q;
  assign variance_o    = var_out_q;
  assign kalman_gain_o = gain_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // reload transaction lands the init registers and a zero gain
  `SKF_ASSERT_NEXT(a_reload_state, clk_i, rst_ni, in_acc && mode_i, (x_q == $past(cfg_ie_q)) && (p_q == $past(cfg_iv_q)) && (k_q == '0))
  // filter transaction always starts with the A*x product
  `SKF_ASSERT_NEXT(a_filter_start, clk_i, rst_ni, in_acc && !mode_i, (state_q == skf_pkg::ST_LOAD) && (op_q == skf_pkg::OP_AX))
  // partial remainder stays below the divisor throughout the division
  `SKF_ASSERT_IMPL(a_div_rem, clk_i, rst_ni, state_q == skf_pkg::ST_DIV, rem_q < den_q)
  // zero denominator forces a zero gain
  `SKF_ASSERT_NEXT(a_zero_den, clk_i, rst_ni, (state_q == skf_pkg::ST_LOAD) && (op_q == skf_pkg::OP_DIV) && (den_q == '0), k_q == '0)

endmodule

### test/scalar_kalman_filter_core_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_filter_core_tb;

  // Local copies of package constants used in widths and shifts.
  localparam int unsigned ADDR_W    = skf_pkg::ADDR_W;
  localparam int unsigned GAIN_FRAC = skf_pkg::GAIN_FRAC;
  localparam int unsigned SQ_SHIFT  = skf_pkg::SQ_SHIFT;

  // Fraction bits of values, variances and the gain (Q16.16).
  localparam int unsigned FRAC = 16;

  // Input mode codes.
  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_RELOAD = 1'b1;

  // Register slots above the last real register: writes there must be dropped.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Random part: a fresh register setting per phase, the last phase without idling.
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 120;

  // Length of the final drain that shows any stray transaction.
  localparam int DRAIN_CYCLES = 120;

  // Wide signed arithmetic so that no intermediate product overflows.
  typedef logic signed [95:0] wide_t;

  localparam wide_t S32_MAX = 96'sd2147483647;
  localparam wide_t S32_MIN = -96'sd2147483648;
  localparam wide_t U32_MAX = 96'sd4294967295;
  localparam wide_t UNITY   = wide_t'(1) <<< FRAC;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic        [31:0] variance;
    logic signed [31:0] kalman_gain;
  } kf_result_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               mode_i;
  logic signed [31:0] measurement_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] estimate_o;
  logic        [31:0] variance_o;
  logic signed [31:0] kalman_gain_o;

  scalar_kalman_filter_core #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .measurement_i(measurement_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .estimate_o   (estimate_o),
    .variance_o   (variance_o),
    .kalman_gain_o(kalman_gain_o)
  );

  // --------------------------------------------------------------------------
  // Mirror of the register file and of the filter state
  // --------------------------------------------------------------------------
  logic signed [15:0] cfg_a;
  logic signed [15:0] cfg_h;
  logic        [31:0] cfg_q;
  logic        [31:0] cfg_r;
  logic signed [31:0] cfg_init_est;
  logic        [31:0] cfg_init_var;
  logic signed [31:0] est_mirror;
  logic        [31:0] var_mirror;

  // Filter outputs still owed by the DUT, oldest first.
  kf_result_t awaited_outputs[$];

  int  fail_count;
  int  n_steps;
  int  n_reloads;
  int  n_zero_gain;
  int  n_var_cleared;
  int  n_checked;
  bit  calm_run;  // no idling on either side once set

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above what a correct run needs.
  initial begin
    #10_000_000;
    $display("Timeout: DUT stopped making progress, %0d results still owed",
             awaited_outputs.size());
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers and the filter predictor
  // --------------------------------------------------------------------------
  function automatic wide_t sat_s32(wide_t v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic wide_t sat_u32(wide_t v);
    if (v > U32_MAX) return U32_MAX;
    return v;
  endfunction

  function automatic void mirror_reset();
    cfg_a        = skf_pkg::RST_STATE_GAIN;
    cfg_h        = skf_pkg::RST_MEAS_GAIN;
    cfg_q        = skf_pkg::RST_PROCESS_NOISE;
    cfg_r        = skf_pkg::RST_MEAS_NOISE;
    cfg_init_est = skf_pkg::RST_INIT_ESTIMATE;
    cfg_init_var = skf_pkg::RST_INIT_VARIANCE;
    est_mirror   = skf_pkg::RST_INIT_ESTIMATE;
    var_mirror   = skf_pkg::RST_INIT_VARIANCE;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] d);
    case (idx)
      skf_pkg::REG_STATE_GAIN:    cfg_a = d[15:0];
      skf_pkg::REG_MEAS_GAIN:     cfg_h = d[15:0];
      skf_pkg::REG_PROCESS_NOISE: cfg_q = d;
      skf_pkg::REG_MEAS_NOISE:    cfg_r = d;
      skf_pkg::REG_INIT_ESTIMATE: cfg_init_est = d;
      skf_pkg::REG_INIT_VARIANCE: cfg_init_var = d;
      default: ;  // unmapped slot, ignored
    endcase
  endfunction

  // One filter step on the mirrored state; returns the output it should give.
  function automatic kf_result_t filter_step(logic mode, logic signed [31:0] z);
    kf_result_t res;
    wide_t a, h, habs, aa, hh, x, p, q, r, zw;
    wide_t x1, p1, num, den, quo, gain, e, x2, gh, f, p2;
    gain = 0;
    if (mode == MODE_RELOAD) begin
      est_mirror = cfg_init_est;
      var_mirror = cfg_init_var;
      n_reloads++;
    end else begin
      a    = cfg_a;
      h    = cfg_h;
      q    = cfg_q;
      r    = cfg_r;
      x    = est_mirror;
      p    = var_mirror;
      zw   = z;
      habs = (h < 0) ? -h : h;
      aa   = a * a;
      hh   = habs * habs;
      // predict
      x1   = sat_s32((a * x) >>> GAIN_FRAC);
      p1   = sat_u32(((aa * p) >>> SQ_SHIFT) + q);
      // gain; a zero denominator leaves it at zero
      num  = (p1 * habs) >>> GAIN_FRAC;
      den  = ((p1 * hh) >>> SQ_SHIFT) + r;
      if (den != 0) begin
        quo = (num <<< FRAC) / den;
        if (quo > S32_MAX + 1) quo = S32_MAX + 1;
        gain = sat_s32((h < 0) ? -quo : quo);
      end
      // correct
      e    = sat_s32(zw - ((h * x1) >>> GAIN_FRAC));
      x2   = sat_s32(x1 + ((gain * e) >>> FRAC));
      gh   = (gain * h) >>> GAIN_FRAC;
      f    = UNITY - gh;
      if (f < 0) f = 0;  // k*H above one: variance collapses to zero
      f    = sat_u32(f);
      p2   = sat_u32((f * p1) >>> FRAC);
      est_mirror = x2[31:0];
      var_mirror = p2[31:0];
      n_steps++;
      if (gain == 0) n_zero_gain++;
      if (p2 == 0) n_var_cleared++;
    end
    res.estimate    = est_mirror;
    res.variance    = var_mirror;
    res.kalman_gain = gain[31:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port (APB-style, pready tied high in the DUT)
  // --------------------------------------------------------------------------
  // All register tasks start and end at a falling edge.
  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = d;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    apply_reg_write(idx, d);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_reg(logic [2:0] idx, output logic [31:0] d);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    d = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Read back every register and compare against the mirror (low bits only
  // for the 16-bit gains).
  task automatic check_registers();
    logic [31:0] d;
    read_reg(skf_pkg::REG_STATE_GAIN, d);
    if (d[15:0] !== cfg_a) begin
      $error("state_gain readback: expected %0d, actual %0d", cfg_a, $signed(d[15:0]));
      fail_count++;
    end
    read_reg(skf_pkg::REG_MEAS_GAIN, d);
    if (d[15:0] !== cfg_h) begin
      $error("meas_gain readback: expected %0d, actual %0d", cfg_h, $signed(d[15:0]));
      fail_count++;
    end
    read_reg(skf_pkg::REG_PROCESS_NOISE, d);
    if (d !== cfg_q) begin
      $error("process_noise readback: expected %0d, actual %0d", cfg_q, d);
      fail_count++;
    end
    read_reg(skf_pkg::REG_MEAS_NOISE, d);
    if (d !== cfg_r) begin
      $error("meas_noise readback: expected %0d, actual %0d", cfg_r, d);
      fail_count++;
    end
    read_reg(skf_pkg::REG_INIT_ESTIMATE, d);
    if (d !== cfg_init_est) begin
      $error("init_estimate readback: expected %0d, actual %0d", cfg_init_est, $signed(d));
      fail_count++;
    end
    read_reg(skf_pkg::REG_INIT_VARIANCE, d);
    if (d !== cfg_init_var) begin
      $error("init_variance readback: expected %0d, actual %0d", cfg_init_var, d);
      fail_count++;
    end
  endtask

  task automatic program_filter(logic signed [15:0] a, logic signed [15:0] h,
                                logic [31:0] q, logic [31:0] r,
                                logic signed [31:0] init_est, logic [31:0] init_var);
    write_reg(skf_pkg::REG_STATE_GAIN, 32'(a));
    write_reg(skf_pkg::REG_MEAS_GAIN, 32'(h));
    write_reg(skf_pkg::REG_PROCESS_NOISE, q);
    write_reg(skf_pkg::REG_MEAS_NOISE, r);
    write_reg(skf_pkg::REG_INIT_ESTIMATE, init_est);
    write_reg(skf_pkg::REG_INIT_VARIANCE, init_var);
  endtask

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------
  // Sends one transaction. Valid stays high between back-to-back transactions;
  // it only drops for an idle burst or when the channel is parked.
  task automatic send_item(logic mode, logic signed [31:0] z);
    if (!calm_run && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    mode_i        = mode;
    measurement_i = z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_outputs.push_back(filter_step(mode, z));
    @(negedge clk_i);
  endtask

  // Park the input channel and let every owed result come back. Each
  // transaction yields exactly one result, so an empty queue means idle.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (awaited_outputs.size() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output channel: random back-pressure and the result checker
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm_run && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;  // start of a stall burst
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    kf_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_outputs.size() == 0) begin
        $error("result transaction with nothing outstanding: estimate %0d", estimate_o);
        fail_count++;
      end else begin
        want = awaited_outputs.pop_front();
        n_checked++;
        if (estimate_o !== want.estimate) begin
          $error("estimate: expected %0d, actual %0d", want.estimate, estimate_o);
          fail_count++;
        end
        if (variance_o !== want.variance) begin
          $error("variance: expected %0d, actual %0d", want.variance, variance_o);
          fail_count++;
        end
        if (kalman_gain_o !== want.kalman_gain) begin
          $error("kalman_gain: expected %0d, actual %0d", want.kalman_gain, kalman_gain_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random value sources
  // --------------------------------------------------------------------------
  // Q4.12 factor: mostly near +/-1.0, sometimes the extremes, zero or anything.
  function automatic logic signed [15:0] rand_factor();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return 16'sd0;
      default: begin
        v = $urandom_range(2048, 6144);
        if ($urandom_range(0, 3) == 0) v = -v;
        return 16'(v);
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 1 << 18);
    endcase
  endfunction

  function automatic logic [31:0] rand_variance();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  // Measurements mostly track the current estimate so the filter does real
  // work; the rest are full-range or extreme values.
  function automatic logic signed [31:0] rand_measurement();
    wide_t w;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: begin
        w = wide_t'(est_mirror) + (wide_t'($urandom_range(0, 1 << 20)) - (1 << 19));
        w = sat_s32(w);
        return w[31:0];
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Registers come out of reset at their documented values; the default
  // filter settles towards a few simple measurements.
  task automatic test_reset_values();
    check_registers();
    send_item(MODE_FILTER, 32'sd65536);
    send_item(MODE_FILTER, -32'sd65536);
    send_item(MODE_FILTER, 32'sd0);
    send_item(MODE_RELOAD, 32'sd0);
  endtask

  // Measurement extremes, and a reload whose measurement must be ignored.
  task automatic test_field_extremes();
    send_item(MODE_FILTER, 32'sh7FFF_FFFF);
    send_item(MODE_FILTER, 32'sh8000_0000);
    send_item(MODE_FILTER, -32'sd1);
    send_item(MODE_FILTER, 32'sd0);
    send_item(MODE_RELOAD, 32'shDEAD_BEEF);
  endtask

  // Zero denominator (no noise, zero variance) and H of zero: gain must be 0.
  task automatic test_zero_gain();
    wait_idle();
    program_filter(16'sd4096, 16'sd4096, 32'd0, 32'd0, 32'sd12345, 32'd0);
    send_item(MODE_RELOAD, 32'sd0);
    send_item(MODE_FILTER, 32'sd655360);
    wait_idle();
    write_reg(skf_pkg::REG_MEAS_GAIN, 32'd0);
    write_reg(skf_pkg::REG_MEAS_NOISE, 32'd6554);
    send_item(MODE_FILTER, -32'sd655360);
  endtask

  // Truncation pushes k*H just past one: the factor clamps and the variance
  // drops to zero.
  task automatic test_gain_above_unity();
    wait_idle();
    program_filter(16'sd4096, 16'sd4097, 32'd0, 32'd0, 32'sd0, 32'd3);
    send_item(MODE_RELOAD, 32'sd0);
    send_item(MODE_FILTER, 32'sd70000);
  endtask

  // Largest factors, state and noise: every saturation point is hit, and a
  // negative H gives a negative gain.
  task automatic test_saturation();
    wait_idle();
    program_filter(16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF, 32'd0,
                   32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_RELOAD, 32'sd0);
    send_item(MODE_FILTER, 32'sh8000_0000);
    send_item(MODE_FILTER, 32'sh7FFF_FFFF);
    wait_idle();
    program_filter(16'sh8000, 16'sh7FFF, 32'd1, 32'hFFFF_FFFF,
                   32'sh8000_0000, 32'hFFFF_FFFF);
    send_item(MODE_RELOAD, 32'sd0);
    send_item(MODE_FILTER, 32'sh7FFF_FFFF);
  endtask

  // Writes to unmapped slots change nothing.
  task automatic test_unmapped_registers();
    wait_idle();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    check_registers();
    send_item(MODE_FILTER, 32'sd1000);
  endtask

  // Bulk random traffic over a series of register settings. Each phase starts
  // from an idle core; the last runs with no idling at all.
  task automatic test_random_phases();
    logic mode;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) calm_run = 1'b1;
      program_filter(rand_factor(), rand_factor(), rand_noise(), rand_noise(),
                     $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 1 << 22) - (1 << 21)),
                     rand_variance());
      if ($urandom_range(0, 1)) send_item(MODE_RELOAD, $urandom);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        mode = ($urandom_range(0, 9) == 0) ? MODE_RELOAD : MODE_FILTER;
        send_item(mode, rand_measurement());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_FILTER;
    measurement_i = '0;
    calm_run      = 1'b0;
    fail_count    = 0;
    n_steps       = 0;
    n_reloads     = 0;
    n_zero_gain   = 0;
    n_var_cleared = 0;
    n_checked     = 0;
    mirror_reset();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_field_extremes();
    test_zero_gain();
    test_gain_above_unity();
    test_saturation();
    test_unmapped_registers();
    test_random_phases();

    // Drain, then give the core time to show any stray transaction.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d filter steps and %0d reloads over %0d register settings; %0d results checked.",
             n_steps, n_reloads, PHASES + 6, n_checked);
    $display("Steps with zero gain: %0d, steps that cleared the variance: %0d.",
             n_zero_gain, n_var_cleared);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/skf_pkg.sv
rtl/scalar_kalman_filter_core.sv
test/scalar_kalman_filter_core_tb.sv
